// ----- src/framed_packet_validator_crc32_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet validator
// Short forms for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_VALIDATOR_CRC32_DEFINES_SVH
`define FRAMED_PACKET_VALIDATOR_CRC32_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define FPV_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define FPV_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fpv_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed packet validator package
// Shared types, register indexes, status codes and the CRC-32 byte step.
// ----------------------------------------------------------------------------
package fpv_pkg;

  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned TRAILER_BYTES = 4;
  localparam int unsigned STAMP_BYTES   = 8;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [31:0] MAGIC_RESET    = 32'h4242_4242;
  localparam logic [15:0] VERSION_RESET  = 16'h0001;
  localparam logic [15:0] TYPE_RESET     = 16'h0001;
  localparam logic [15:0] MIN_BODY_RESET = 16'd112;

  typedef enum logic [1:0] {
    REG_MAGIC    = 2'd0,
    REG_VERSION  = 2'd1,
    REG_TYPE     = 2'd2,
    REG_MIN_BODY = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_CRC_BAD    = 3'd1,
    ST_HEADER_BAD = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_BODY_SMALL = 3'd4
  } status_t;

  // Everything the checks need about one finished message.
  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] ptype;
    logic [31:0] body_len;
    logic [31:0] sequence_no;
    logic [31:0] size;
    logic [31:0] crc;
    logic [31:0] trailer;
    logic [63:0] stamp;
  } msg_t;

  // One byte of the reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'h00_0000, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/fpv_byte_if.sv -----
// ----------------------------------------------------------------------------
// Byte stream channel
// Carries one message byte per item, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface fpv_byte_if import fpv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/fpv_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data to be written to it.
// ----------------------------------------------------------------------------
interface fpv_cfg_if import fpv_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_reg_t    index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/fpv_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Carries the verdict on one message together with the retained packet data.
// ----------------------------------------------------------------------------
interface fpv_res_if import fpv_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] sequence_res;
  logic [63:0] timestamp;
  logic [31:0] received_crc;
  logic [31:0] computed_crc;
  logic        have_truth;
  logic [31:0] stored_sequence;
  logic [63:0] stored_timestamp;

  modport source (output valid, output status, output sequence_res, output timestamp,
                  output received_crc, output computed_crc, output have_truth,
                  output stored_sequence, output stored_timestamp, input ready);
  modport sink   (input valid, input status, input sequence_res, input timestamp,
                  input received_crc, input computed_crc, input have_truth,
                  input stored_sequence, input stored_timestamp, output ready);
endinterface

// ----- src/framed_packet_validator_crc32.sv -----
// ----------------------------------------------------------------------------
// Framed packet validator with CRC-32
// Bytes of a message enter on rx, one item per byte, with last_byte set on the
// final byte. Each message yields one result item on res: a status, the
// header sequence, the timestamp, both CRC words and the retained data of the
// last accepted packet. Registers are written over cfg, which is always ready.
// Throughput is one byte per cycle while the queue has room; the CRC step and
// field capture of the front end are combinational. A message summary enters
// the queue at the clock edge that accepts its final byte and moves into the
// result register once that register is empty or being taken by res.ready.
// While res is stalled the result holds and up to QUEUE_DEPTH further message
// summaries wait in the queue; once it is full, rx.ready falls.
// Reset clears message state, the queue, the retained packet and the result
// valid flag and restores the register defaults.
// ----------------------------------------------------------------------------
module framed_packet_validator_crc32 import fpv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  fpv_byte_if.sink  rx,
  fpv_cfg_if.sink   cfg,
  fpv_res_if.source res
);

  // Front end to queue.
  logic q_push;
  logic q_room;
  msg_t q_in;

  // Queue to checking stage.
  logic q_pop;
  logic q_filled;
  msg_t q_out;

  // Byte assembly, field capture and CRC, one byte per cycle with queue room.
  fpv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_room (q_room),
    .q_push (q_push),
    .q_data (q_in)
  );

  // The queue lets the byte side run on while a result waits to be taken.
  fpv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .room      (q_room),
    .pop       (q_pop),
    .pop_data  (q_out),
    .filled    (q_filled)
  );

  // Header, length and CRC checks against the registers; result register.
  fpv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .res      (res),
    .q_filled (q_filled),
    .q_data   (q_out),
    .q_pop    (q_pop)
  );

endmodule

// ----- src/fpv_front.sv -----
// ----------------------------------------------------------------------------
// Framed packet validator front end
// Takes one byte per cycle while the queue has room, captures header, timestamp
// and trailer fields, runs the CRC and queues a summary on the final byte.
// ----------------------------------------------------------------------------
module fpv_front import fpv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  fpv_byte_if.sink rx,
  input  logic     q_room,
  output logic     q_push,
  output msg_t     q_data
);

  logic [31:0]      byte_count;
  logic [31:0]      byte_count_next;
  logic [1:0][63:0] header_words;
  logic [1:0][63:0] header_words_next;
  logic [31:0]      crc_running;
  logic [31:0]      crc_running_next;
  logic [31:0]      trailer_crc;
  logic [31:0]      trailer_crc_next;
  logic [63:0]      stamp_capture;
  logic [63:0]      stamp_capture_next;

  logic        accept;
  logic        in_header;
  logic        in_body;
  logic [31:0] body_offset;
  logic [31:0] trailer_offset;
  logic [31:0] body_len;

  assign rx.ready = q_room;
  assign accept   = rx.valid & rx.ready;

  assign body_len       = header_words[1][31:0];
  assign in_header      = (byte_count < 32'(HEADER_BYTES));
  assign body_offset    = byte_count - 32'(HEADER_BYTES);
  assign in_body        = (body_offset < body_len);
  assign trailer_offset = body_offset - body_len;

  always_comb begin
    header_words_next  = header_words;
    crc_running_next   = crc_running;
    trailer_crc_next   = trailer_crc;
    stamp_capture_next = stamp_capture;

    if (in_header) begin
      header_words_next[byte_count[3]][{byte_count[2:0], 3'b000} +: 8] = rx.data_byte;
      crc_running_next = crc_byte(crc_running, rx.data_byte);
    end else begin
      if (body_offset < 32'(STAMP_BYTES)) begin
        stamp_capture_next[{body_offset[2:0], 3'b000} +: 8] = rx.data_byte;
      end
      if (in_body) begin
        crc_running_next = crc_byte(crc_running, rx.data_byte);
      end else if (trailer_offset < 32'(TRAILER_BYTES)) begin
        trailer_crc_next[{trailer_offset[1:0], 3'b000} +: 8] = rx.data_byte;
      end
    end

    // The counter sticks at its top value; later bytes count as that position.
    byte_count_next = (&byte_count) ? byte_count : byte_count + 32'd1;
  end

  assign q_push              = accept & rx.last_byte;
  assign q_data.magic        = header_words_next[0][31:0];
  assign q_data.version      = header_words_next[0][47:32];
  assign q_data.ptype        = header_words_next[0][63:48];
  assign q_data.body_len     = header_words_next[1][31:0];
  assign q_data.sequence_no  = header_words_next[1][63:32];
  assign q_data.size         = byte_count_next;
  assign q_data.crc          = ~crc_running_next;
  assign q_data.trailer      = trailer_crc_next;
  assign q_data.stamp        = stamp_capture_next;

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      byte_count    <= '0;
      header_words  <= '0;
      crc_running   <= CRC_INIT;
      trailer_crc   <= '0;
      stamp_capture <= '0;
    end else if (accept) begin
      byte_count    <= byte_count_next;
      header_words  <= header_words_next;
      crc_running   <= crc_running_next;
      trailer_crc   <= trailer_crc_next;
      stamp_capture <= stamp_capture_next;
    end
  end

endmodule

// ----- src/fpv_queue.sv -----
// ----------------------------------------------------------------------------
// Framed packet validator summary queue
// A short first-in first-out store of message summaries between the front
// end and the checking stage.
// ----------------------------------------------------------------------------
module fpv_queue import fpv_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  msg_t push_data,
  output logic room,
  input  logic pop,
  output msg_t pop_data,
  output logic filled
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  msg_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign room     = (fill != CNT_W'(DEPTH));
  assign filled   = (fill != '0);
  assign do_push  = push & room;
  assign do_pop   = pop & filled;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/fpv_back.sv -----
// ----------------------------------------------------------------------------
// Framed packet validator checking stage
// Holds the configuration registers, judges each message summary, keeps the
// last accepted packet and drives the registered result channel.
// ----------------------------------------------------------------------------
module fpv_back import fpv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fpv_cfg_if.sink    cfg,
  fpv_res_if.source  res,
  input  logic       q_filled,
  input  msg_t       q_data,
  output logic       q_pop
);

  logic [31:0] expected_magic;
  logic [15:0] expected_version;
  logic [15:0] expected_type;
  logic [15:0] min_body_length;

  logic [31:0] kept_sequence;
  logic [63:0] kept_timestamp;
  logic        truth_flag;

  logic        out_valid;
  status_t     out_status;
  logic [31:0] out_sequence;
  logic [63:0] out_timestamp;
  logic [31:0] out_received;
  logic [31:0] out_computed;

  status_t     verdict;
  logic [32:0] full_size;
  logic        passed;
  logic        shows_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= MAGIC_RESET;
      expected_version <= VERSION_RESET;
      expected_type    <= TYPE_RESET;
      min_body_length  <= MIN_BODY_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MAGIC:    expected_magic   <= cfg.data;
        REG_VERSION:  expected_version <= cfg.data[15:0];
        REG_TYPE:     expected_type    <= cfg.data[15:0];
        REG_MIN_BODY: min_body_length  <= cfg.data[15:0];
        default:      ;
      endcase
    end
  end

  // Checks in priority order; the first that fails sets the status.
  assign full_size = 33'(HEADER_BYTES + TRAILER_BYTES) + {1'b0, q_data.body_len};

  always_comb begin
    if (q_data.size < 32'(HEADER_BYTES + TRAILER_BYTES)) begin
      verdict = ST_TOO_SHORT;
    end else if (q_data.magic != expected_magic || q_data.version != expected_version ||
                 q_data.ptype != expected_type) begin
      verdict = ST_HEADER_BAD;
    end else if (q_data.body_len < {16'h0000, min_body_length}) begin
      verdict = ST_BODY_SMALL;
    end else if ({1'b0, q_data.size} < full_size) begin
      verdict = ST_TOO_SHORT;
    end else if (q_data.trailer != q_data.crc) begin
      verdict = ST_CRC_BAD;
    end else begin
      verdict = ST_ACCEPTED;
    end
  end

  assign passed     = (verdict == ST_ACCEPTED);
  assign shows_data = passed || (verdict == ST_CRC_BAD);
  assign q_pop      = q_filled && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      kept_sequence  <= '0;
      kept_timestamp <= '0;
      truth_flag     <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop && passed) begin
        kept_sequence  <= q_data.sequence_no;
        kept_timestamp <= q_data.stamp;
        truth_flag     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_status    <= verdict;
      out_sequence  <= shows_data ? q_data.sequence_no : '0;
      out_timestamp <= shows_data ? q_data.stamp       : '0;
      out_received  <= shows_data ? q_data.trailer     : '0;
      out_computed  <= shows_data ? q_data.crc         : '0;
    end
  end

  assign res.valid            = out_valid;
  assign res.status           = out_status;
  assign res.sequence_res     = out_sequence;
  assign res.timestamp        = out_timestamp;
  assign res.received_crc     = out_received;
  assign res.computed_crc     = out_computed;
  assign res.have_truth       = truth_flag;
  assign res.stored_sequence  = kept_sequence;
  assign res.stored_timestamp = kept_timestamp;

endmodule

// ----- src/fpv_checker.sv -----
// ----------------------------------------------------------------------------
// Framed packet validator port checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "framed_packet_validator_crc32_defines.svh"

module fpv_checker import fpv_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  status,
  input logic [31:0] sequence_res,
  input logic [63:0] timestamp,
  input logic [31:0] received_crc,
  input logic [31:0] computed_crc,
  input logic        have_truth,
  input logic [31:0] stored_sequence,
  input logic [63:0] stored_timestamp
);

  `FPV_CHECK(a_idle_after_reset, clk, rst, $past(rst), !res_valid, "result after reset")

  `FPV_CHECK_NEXT(a_hold_on_stall, clk, rst, res_valid && !res_ready,
    res_valid && $stable(status) && $stable(sequence_res) && $stable(computed_crc),
    "stalled result changed")

  `FPV_CHECK(a_rejected_zeroed, clk, rst,
    res_valid && (status == ST_HEADER_BAD || status == ST_TOO_SHORT ||
                  status == ST_BODY_SMALL),
    sequence_res == '0 && timestamp == '0 && received_crc == '0 && computed_crc == '0,
    "rejected message shows data")

  `FPV_CHECK(a_accept_kept, clk, rst, res_valid && status == ST_ACCEPTED,
    have_truth && stored_sequence == sequence_res && stored_timestamp == timestamp &&
    received_crc == computed_crc,
    "accepted packet not retained")

endmodule

bind framed_packet_validator_crc32 fpv_checker u_fpv_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .status           (res.status),
  .sequence_res     (res.sequence_res),
  .timestamp        (res.timestamp),
  .received_crc     (res.received_crc),
  .computed_crc     (res.computed_crc),
  .have_truth       (res.have_truth),
  .stored_sequence  (res.stored_sequence),
  .stored_timestamp (res.stored_timestamp)
);

// ----- dv/fpv_dv_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet validator test helpers
// CRC-32 byte step shared by the frame builder and the result predictor.
// ----------------------------------------------------------------------------
package fpv_dv_pkg;

  // Reflected CRC-32, polynomial 0xEDB88320, one byte, LSB first.
  function automatic logic [31:0] crc32_update(input logic [31:0] acc,
                                               input logic [7:0]  b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- dv/fpv_verdict_scoreboard.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet validator scoreboard
// Follows the byte, register and result channels, predicts each verdict and
// compares every result item with the oldest prediction.
// ----------------------------------------------------------------------------
module fpv_verdict_scoreboard import fpv_pkg::*; import fpv_dv_pkg::*; (
  input  logic clk,
  input  logic rst,
  fpv_byte_if  rx,
  fpv_cfg_if   cfg,
  fpv_res_if   res,
  output int   mismatches,
  output int   outstanding
);

  typedef struct {
    status_t     status;
    logic [31:0] sequence_no;
    logic [63:0] stamp;
    logic [31:0] trailer;
    logic [31:0] crc;
    logic        truth;
    logic [31:0] kept_seq;
    logic [63:0] kept_stamp;
  } verdict_t;

  verdict_t expected_verdicts[$];

  // Register copies.
  logic [31:0] want_magic;
  logic [15:0] want_version;
  logic [15:0] want_type;
  logic [15:0] want_min_body;

  // Per-message state.
  logic [31:0] byte_pos;
  logic [63:0] head_lo;
  logic [63:0] head_hi;
  logic [31:0] crc_acc;
  logic [31:0] trailer_word;
  logic [63:0] stamp_word;

  // Data of the last accepted packet.
  logic [31:0] keep_seq;
  logic [63:0] keep_stamp;
  logic        keep_truth;

  int result_no;

  task automatic clear_frame();
    byte_pos     = '0;
    head_lo      = '0;
    head_hi      = '0;
    crc_acc      = '1;
    trailer_word = '0;
    stamp_word   = '0;
  endtask

  task automatic advance_frame(input logic [7:0] b, input logic fin);
    logic [31:0] blen;
    logic [31:0] off;
    logic [31:0] past;
    logic [63:0] need;
    verdict_t    v;
    blen = head_hi[31:0];
    if (byte_pos < HEADER_BYTES) begin
      if (byte_pos < 8) head_lo[{byte_pos[2:0], 3'b000} +: 8] = b;
      else head_hi[{byte_pos[2:0], 3'b000} +: 8] = b;
      crc_acc = crc32_update(crc_acc, b);
    end else begin
      off = byte_pos - HEADER_BYTES;
      if (off < STAMP_BYTES) stamp_word[{off[2:0], 3'b000} +: 8] = b;
      if (off < blen) begin
        crc_acc = crc32_update(crc_acc, b);
      end else begin
        past = off - blen;
        if (past < TRAILER_BYTES) trailer_word[{past[1:0], 3'b000} +: 8] = b;
      end
    end
    if (byte_pos != '1) byte_pos = byte_pos + 1;
    if (fin) begin
      blen = head_hi[31:0];
      need = {32'd0, blen} + HEADER_BYTES + TRAILER_BYTES;
      if (byte_pos < HEADER_BYTES + TRAILER_BYTES) v.status = ST_TOO_SHORT;
      else if (head_lo[31:0] != want_magic || head_lo[47:32] != want_version ||
               head_lo[63:48] != want_type) v.status = ST_HEADER_BAD;
      else if (blen < {16'd0, want_min_body}) v.status = ST_BODY_SMALL;
      else if ({32'd0, byte_pos} < need) v.status = ST_TOO_SHORT;
      else if (trailer_word != ~crc_acc) v.status = ST_CRC_BAD;
      else v.status = ST_ACCEPTED;
      if (v.status == ST_ACCEPTED) begin
        keep_seq   = head_hi[63:32];
        keep_stamp = stamp_word;
        keep_truth = 1'b1;
      end
      if (v.status == ST_ACCEPTED || v.status == ST_CRC_BAD) begin
        v.sequence_no = head_hi[63:32];
        v.stamp       = stamp_word;
        v.trailer     = trailer_word;
        v.crc         = ~crc_acc;
      end else begin
        v.sequence_no = '0;
        v.stamp       = '0;
        v.trailer     = '0;
        v.crc         = '0;
      end
      v.truth      = keep_truth;
      v.kept_seq   = keep_seq;
      v.kept_stamp = keep_stamp;
      expected_verdicts.push_back(v);
      clear_frame();
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: result %0d, %s is %h, expected %h", $time, result_no, field, got, want);
    mismatches++;
  endtask

  task automatic compare_verdict(input verdict_t w);
    if (res.status !== w.status) flag_mismatch("status", res.status, w.status);
    if (res.sequence_res !== w.sequence_no)
      flag_mismatch("sequence_res", res.sequence_res, w.sequence_no);
    if (res.timestamp !== w.stamp) flag_mismatch("timestamp", res.timestamp, w.stamp);
    if (res.received_crc !== w.trailer)
      flag_mismatch("received_crc", res.received_crc, w.trailer);
    if (res.computed_crc !== w.crc) flag_mismatch("computed_crc", res.computed_crc, w.crc);
    if (res.have_truth !== w.truth) flag_mismatch("have_truth", res.have_truth, w.truth);
    if (res.stored_sequence !== w.kept_seq)
      flag_mismatch("stored_sequence", res.stored_sequence, w.kept_seq);
    if (res.stored_timestamp !== w.kept_stamp)
      flag_mismatch("stored_timestamp", res.stored_timestamp, w.kept_stamp);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want_magic    = MAGIC_RESET;
      want_version  = VERSION_RESET;
      want_type     = TYPE_RESET;
      want_min_body = MIN_BODY_RESET;
      clear_frame();
      keep_seq   = '0;
      keep_stamp = '0;
      keep_truth = 1'b0;
      expected_verdicts.delete();
      mismatches = 0;
      result_no  = 0;
    end else begin
      // Results are taken first, so that a stray one never consumes the
      // prediction made at this same edge.
      if (res.valid && res.ready) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result with nothing expected", 64'd0, 64'd0);
        end else begin
          compare_verdict(expected_verdicts.pop_front());
        end
        result_no++;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MAGIC:    want_magic    = cfg.data;
          REG_VERSION:  want_version  = cfg.data[15:0];
          REG_TYPE:     want_type     = cfg.data[15:0];
          REG_MIN_BODY: want_min_body = cfg.data[15:0];
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) advance_frame(rx.data_byte, rx.last_byte);
    end
    outstanding <= expected_verdicts.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet validator testbench
// Builds framed messages (good, corrupted, truncated, oversized and noise),
// streams them byte by byte with random gaps, stalls the result channel at
// random, and lets the scoreboard judge every verdict.
// ----------------------------------------------------------------------------
module tb;
  import fpv_pkg::*;
  import fpv_dv_pkg::*;

  // Shapes of message the frame builder can produce. A complete frame carries
  // its whole body and trailer; the others are cut short or padded out.
  typedef enum {
    FR_GOOD,
    FR_BAD_CRC,
    FR_EXTRA,
    FR_BAD_MAGIC,
    FR_BAD_VERSION,
    FR_BAD_TYPE,
    FR_SMALL_BODY,
    FR_TRUNCATED,
    FR_TINY,
    FR_HUGE,
    FR_NOISE
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fpv_byte_if rx_ch ();
  fpv_cfg_if  cfg_ch ();
  fpv_res_if  res_ch ();

  int mismatches;
  int outstanding;

  framed_packet_validator_crc32 dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  fpv_verdict_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .cfg         (cfg_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The shadow of the registers, used only to build frames that pass or
  // fail on purpose. The scoreboard keeps its own copy from the channel.
  logic [31:0] cur_magic   = MAGIC_RESET;
  logic [15:0] cur_version = VERSION_RESET;
  logic [15:0] cur_type    = TYPE_RESET;
  logic [15:0] cur_min     = MIN_BODY_RESET;

  logic [7:0]  frame_bytes[$];
  int unsigned bytes_sent = 0;
  logic        feed_stalls = 1'b1;
  logic        drain_stalls = 1'b1;
  logic        drain_ready = 1'b0;
  int          drain_hold = 0;

  assign res_ch.ready = drain_ready;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The result side: ready by default, with stalls of random length while
  // stalling is switched on for the current phase.
  always @(posedge clk) begin
    if (rst) begin
      drain_ready <= 1'b0;
      drain_hold  <= 0;
    end else if (drain_hold != 0) begin
      drain_ready <= 1'b0;
      drain_hold  <= drain_hold - 1;
    end else begin
      drain_ready <= 1'b1;
      if (drain_stalls && $urandom_range(0, 99) < 20) drain_hold <= idle_cycles();
    end
  end

  // One byte item. Valid is lowered only for a gap, so that back-to-back
  // bytes keep it high and it never sees two assignments in one step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = feed_stalls ? idle_cycles() : 0;
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.data_byte <= b;
    rx_ch.last_byte <= fin;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    bytes_sent += frame_bytes.size();
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Writes all four registers back to back. The upper half of the data word
  // of a 16-bit register carries junk, which the block must discard.
  task automatic apply_config(input logic [31:0] magic, input logic [15:0] version,
                              input logic [15:0] ptype, input logic [15:0] min_body);
    logic [15:0] junk;
    cur_magic   = magic;
    cur_version = version;
    cur_type    = ptype;
    cur_min     = min_body;
    write_reg(REG_MAGIC, magic);
    junk = 16'($urandom);
    write_reg(REG_VERSION, {junk, version});
    junk = 16'($urandom);
    write_reg(REG_TYPE, {junk, ptype});
    junk = 16'($urandom);
    write_reg(REG_MIN_BODY, {junk, min_body});
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Lets every outstanding verdict drain and waits on afterwards so that no
  // message is still in the block when the registers change.
  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Fills frame_bytes with one message. blen is the body length written in
  // the header; cut, where non-zero, is the length a cut-down frame keeps.
  task automatic build_frame(input frame_kind_t kind, input int unsigned blen,
                             input int unsigned cut);
    logic [31:0]  magic;
    logic [15:0]  version;
    logic [15:0]  ptype;
    logic [31:0]  len_field;
    logic [31:0]  crc;
    logic [127:0] head;
    logic [7:0]   b;
    int unsigned  body_n;
    int unsigned  keep_n;
    frame_bytes.delete();
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
      return;
    end
    magic   = cur_magic;
    version = cur_version;
    ptype   = cur_type;
    case (kind)
      FR_BAD_MAGIC:   magic   = magic ^ (32'd1 << $urandom_range(0, 31));
      FR_BAD_VERSION: version = version ^ (16'd1 << $urandom_range(0, 15));
      FR_BAD_TYPE:    ptype   = ptype ^ (16'd1 << $urandom_range(0, 15));
      default: ;
    endcase
    len_field = blen;
    body_n    = blen;
    if (kind == FR_HUGE) begin
      // A length far beyond anything that actually follows.
      len_field = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h0001_0000);
      body_n    = $urandom_range(4, 24);
    end else if (kind != FR_GOOD && kind != FR_BAD_CRC && kind != FR_EXTRA &&
                 body_n > 48) begin
      // The verdict of an incomplete or rejected frame does not need the whole
      // body, so long bodies are cut to keep the run short.
      body_n = 48;
    end
    head = {32'($urandom), len_field, ptype, version, magic};
    crc  = '1;
    for (int i = 0; i < 16; i++) begin
      frame_bytes.push_back(head[8*i +: 8]);
      crc = crc32_update(crc, head[8*i +: 8]);
    end
    for (int unsigned i = 0; i < body_n; i++) begin
      b = 8'($urandom);
      frame_bytes.push_back(b);
      crc = crc32_update(crc, b);
    end
    if (kind == FR_HUGE) return;
    crc = ~crc;
    if (kind == FR_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++) frame_bytes.push_back(crc[8*i +: 8]);
    if (kind == FR_EXTRA) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
    end
    if (kind == FR_TRUNCATED) begin
      // Long enough for the header checks, one byte or more short of the end.
      keep_n = (cut != 0) ? cut : $urandom_range(20, 19 + ((blen > 48) ? 48 : blen));
      while (frame_bytes.size() > keep_n) void'(frame_bytes.pop_back());
    end else if (kind == FR_TINY) begin
      keep_n = (cut != 0) ? cut : $urandom_range(1, 19);
      while (frame_bytes.size() > keep_n) void'(frame_bytes.pop_back());
    end
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    frame_kind_t k;
    r = $urandom_range(0, 99);
    if (r < 60)      k = FR_GOOD;
    else if (r < 68) k = FR_BAD_CRC;
    else if (r < 73) k = FR_EXTRA;
    else if (r < 76) k = FR_BAD_MAGIC;
    else if (r < 79) k = FR_BAD_VERSION;
    else if (r < 82) k = FR_BAD_TYPE;
    else if (r < 87) k = FR_SMALL_BODY;
    else if (r < 92) k = FR_TRUNCATED;
    else if (r < 94) k = FR_TINY;
    else if (r < 96) k = FR_HUGE;
    else             k = FR_NOISE;
    // With a very large minimum a complete frame would be tens of thousands
    // of bytes; such phases send cut-down frames instead.
    if (cur_min > 200 && (k == FR_GOOD || k == FR_BAD_CRC || k == FR_EXTRA)) k = FR_TRUNCATED;
    return k;
  endfunction

  function automatic int unsigned pick_body_len(input frame_kind_t kind);
    if (kind == FR_SMALL_BODY) begin
      return (cur_min > 48) ? $urandom_range(0, 48) : $urandom_range(0, cur_min - 1);
    end
    if ($urandom_range(0, 9) < 8) return cur_min + $urandom_range(0, 6);
    return cur_min + $urandom_range(7, 40);
  endfunction

  initial begin
    frame_kind_t kind;
    int unsigned random_start;
    int unsigned budget;
    int          phase;

    rx_ch.valid      <= 1'b0;
    rx_ch.data_byte  <= 8'd0;
    rx_ch.last_byte  <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_MAGIC;
    cfg_ch.data      <= 32'd0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first under the reset values of the registers: a packet
    // at exactly the default minimum, one a byte below it, and a message
    // that ends on its very first byte.
    build_frame(FR_GOOD, MIN_BODY_RESET, 0);
    send_frame();
    build_frame(FR_SMALL_BODY, MIN_BODY_RESET - 1, 0);
    send_frame();
    build_frame(FR_TINY, 0, 1);
    send_frame();
    wait_idle();

    // Then at the smallest minimum, each way a message can pass or fail.
    apply_config($urandom, 16'($urandom), 16'($urandom), 16'd8);
    build_frame(FR_GOOD, 8, 0);
    send_frame();
    build_frame(FR_BAD_CRC, 8, 0);
    send_frame();
    build_frame(FR_BAD_MAGIC, 9, 0);
    send_frame();
    build_frame(FR_BAD_VERSION, 9, 0);
    send_frame();
    build_frame(FR_BAD_TYPE, 9, 0);
    send_frame();
    build_frame(FR_SMALL_BODY, 7, 0);
    send_frame();
    build_frame(FR_SMALL_BODY, 0, 0);
    send_frame();
    // Nineteen bytes: header complete, still below the shortest frame.
    build_frame(FR_TINY, 0, 19);
    send_frame();
    // One byte short of the trailer's end.
    build_frame(FR_TRUNCATED, 10, 29);
    send_frame();
    // Trailing bytes after a good trailer are ignored.
    build_frame(FR_EXTRA, 12, 0);
    send_frame();
    build_frame(FR_HUGE, 0, 0);
    send_frame();
    build_frame(FR_NOISE, 0, 0);
    send_frame();

    // Random part, in phases of a fixed setting each. The first three phases
    // hold the extremes and the reset values; the rest use random registers
    // with small minimums so that most frames stay short.
    random_start = bytes_sent;
    phase = 0;
    while (bytes_sent - random_start < 1100) begin
      wait_idle();
      case (phase)
        0:       apply_config(32'd0, 16'd0, 16'd0, 16'd8);
        1:       apply_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2:       apply_config(MAGIC_RESET, VERSION_RESET, TYPE_RESET, MIN_BODY_RESET);
        default: apply_config($urandom, 16'($urandom), 16'($urandom),
                              16'($urandom_range(8, 24)));
      endcase
      // Some phases run with no gaps at all on one side or the other.
      feed_stalls = ($urandom_range(0, 3) != 0);
      drain_stalls <= ($urandom_range(0, 3) != 0);
      budget = bytes_sent + 150;
      while (bytes_sent < budget) begin
        kind = pick_kind();
        build_frame(kind, pick_body_len(kind), 0);
        send_frame();
      end
      phase++;
    end

    // Drain, then leave room for any stray result to show itself.
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[framed_packet_validator_crc32] OK");
    end else begin
      $display("[framed_packet_validator_crc32] ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin
    #4000000;
    $display("[framed_packet_validator_crc32] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/fpv_pkg.sv
src/fpv_byte_if.sv
src/fpv_cfg_if.sv
src/fpv_res_if.sv
src/fpv_front.sv
src/fpv_queue.sv
src/fpv_back.sv
src/framed_packet_validator_crc32.sv
src/fpv_checker.sv
dv/fpv_dv_pkg.sv
dv/fpv_verdict_scoreboard.sv
dv/tb.sv
